// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the quadrature counter
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/dqc_pkg.sv =====
// shared types and constants of the debounced quadrature counter
// no dependencies
package dqc_pkg;

  // width of position, limits and the configuration data
  localparam int DATA_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_SAMPLES = 3'd0,
    CFG_EDGE_MODE        = 3'd1,
    CFG_STEP_SIZE        = 3'd2,
    CFG_MIN_LIMIT        = 3'd3,
    CFG_MAX_LIMIT        = 3'd4,
    CFG_FREQ_WINDOW      = 3'd5
  } cfg_reg_t;

  // which debounced edges move the position
  typedef enum logic [1:0] {
    EDGE_FALLING = 2'd0,
    EDGE_RISING  = 2'd1,
    EDGE_BOTH    = 2'd2,
    EDGE_NONE    = 2'd3
  } edge_mode_t;

  // confirmed edges of debounced channel a
  typedef struct packed {
    logic rise;
    logic fall;
  } a_edge_t;

  // reset values and disable codes
  localparam logic [DATA_W-1:0] LIMIT_OFF_LOW  = 16'hFFFF;
  localparam logic [DATA_W-1:0] LIMIT_OFF_HIGH = 16'h0000;
  localparam logic [DATA_W-1:0] STEP_DEFAULT   = 16'd1;
  localparam logic [DATA_W-1:0] WINDOW_DEFAULT = 16'd1000;

endpackage

// ===== rtl/core/dqc_debounce.sv =====
// debounce of channel a with edge confirmation
// depends on dqc_pkg
module dqc_debounce #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         a,
  input  logic [dqc_pkg::DATA_W-1:0]   debounce_samples,
  output dqc_pkg::a_edge_t             edges,
  output logic                         level_q,
  output logic                         level_next
);

  localparam int CMP_W = (COUNTER_WIDTH > dqc_pkg::DATA_W) ? COUNTER_WIDTH : dqc_pkg::DATA_W;

  logic [COUNTER_WIDTH-1:0] count;
  logic [COUNTER_WIDTH-1:0] count_next;
  logic [COUNTER_WIDTH-1:0] count_inc;
  logic [CMP_W-1:0]         count_cmp;
  logic [CMP_W-1:0]         samples_cmp;

  assign count_inc   = COUNTER_WIDTH'(count + 1'b1);
  assign count_cmp   = CMP_W'(count_inc);
  assign samples_cmp = CMP_W'(debounce_samples);

  // rising change confirms at the threshold, falling change above it
  always_comb begin
    edges      = '0;
    count_next = '0;
    level_next = level_q;
    if (a != level_q) begin
      if (a) begin
        edges.rise = (count_cmp >= samples_cmp);
      end else begin
        edges.fall = (count_cmp > samples_cmp);
      end
      if (edges.rise || edges.fall) begin
        level_next = a;
      end else begin
        count_next = count_inc;
      end
    end
  end

  // debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_q <= 1'b0;
      count   <= '0;
    end else if (adv) begin
      level_q <= level_next;
      count   <= count_next;
    end
  end

endmodule

// ===== rtl/core/dqc_position.sv =====
// position accumulator with step, direction and limit clamp
// depends on dqc_pkg
module dqc_position (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  dqc_pkg::a_edge_t             edges,
  input  logic                         b,
  input  logic                         overwrite_valid,
  input  logic [dqc_pkg::DATA_W-1:0]   overwrite_value,
  input  dqc_pkg::edge_mode_t          edge_mode,
  input  logic [dqc_pkg::DATA_W-1:0]   step_size,
  input  logic [dqc_pkg::DATA_W-1:0]   min_limit,
  input  logic [dqc_pkg::DATA_W-1:0]   max_limit,
  output logic [dqc_pkg::DATA_W-1:0]   pos_q,
  output logic [dqc_pkg::DATA_W-1:0]   pos_next
);

  localparam int SUM_W = dqc_pkg::DATA_W + 2;

  logic [dqc_pkg::DATA_W-1:0] base;
  logic                       move;
  logic                       up;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    clamp_hi;
  logic signed [SUM_W-1:0]    clamped;
  logic signed [SUM_W-1:0]    max_s;
  logic signed [SUM_W-1:0]    min_s;

  assign base = overwrite_valid ? overwrite_value : pos_q;

  // edge selection by mode
  always_comb begin
    unique case (edge_mode)
      dqc_pkg::EDGE_FALLING: move = edges.fall;
      dqc_pkg::EDGE_RISING:  move = edges.rise;
      dqc_pkg::EDGE_BOTH:    move = edges.rise || edges.fall;
      dqc_pkg::EDGE_NONE:    move = 1'b0;
      default:               move = 1'b0;
    endcase
  end

  // rising edge follows b, falling edge the inverse of b
  assign up = edges.rise ? b : !b;

  assign max_s = $signed({2'b00, max_limit});
  assign min_s = $signed({2'b00, min_limit});

  // exact sum, then upper clamp, then lower clamp
  always_comb begin
    if (up) begin
      sum = $signed({2'b00, base}) + $signed({2'b00, step_size});
    end else begin
      sum = $signed({2'b00, base}) - $signed({2'b00, step_size});
    end
    clamp_hi = sum;
    if ((max_limit != dqc_pkg::LIMIT_OFF_HIGH) && (sum > max_s)) begin
      clamp_hi = max_s;
    end
    clamped = clamp_hi;
    if ((min_limit != dqc_pkg::LIMIT_OFF_LOW) && (clamp_hi < min_s)) begin
      clamped = min_s;
    end
  end

  assign pos_next = move ? clamped[dqc_pkg::DATA_W-1:0] : base;

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_q <= '0;
    end else if (adv) begin
      pos_q <= pos_next;
    end
  end

endmodule

// ===== rtl/core/dqc_freq.sv =====
// rising edge frequency over a window of ticks
// depends on dqc_pkg
module dqc_freq #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         clear,
  input  logic                         rise,
  input  logic [dqc_pkg::DATA_W-1:0]   freq_window,
  output logic [dqc_pkg::DATA_W-1:0]   freq_next
);

  localparam int CMP_W = (COUNTER_WIDTH > dqc_pkg::DATA_W) ? COUNTER_WIDTH : dqc_pkg::DATA_W;

  logic [COUNTER_WIDTH-1:0]   tally;
  logic [COUNTER_WIDTH-1:0]   tally_inc;
  logic [COUNTER_WIDTH-1:0]   tally_next;
  logic [COUNTER_WIDTH-1:0]   ticks;
  logic [COUNTER_WIDTH-1:0]   ticks_inc;
  logic [COUNTER_WIDTH-1:0]   ticks_next;
  logic [dqc_pkg::DATA_W-1:0] last_freq;

  assign tally_inc = rise ? COUNTER_WIDTH'(tally + 1'b1) : tally;
  assign ticks_inc = COUNTER_WIDTH'(ticks + 1'b1);

  // window close latches the tally and restarts both counters
  always_comb begin
    tally_next = tally_inc;
    ticks_next = ticks;
    freq_next  = last_freq;
    if (freq_window != '0) begin
      ticks_next = ticks_inc;
      if (CMP_W'(ticks_inc) >= CMP_W'(freq_window)) begin
        freq_next  = dqc_pkg::DATA_W'(tally_inc);
        tally_next = '0;
        ticks_next = '0;
      end
    end
  end

  // window state, cleared by reset and by a write of the window register
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      tally     <= '0;
      ticks     <= '0;
      last_freq <= '0;
    end else if (adv) begin
      tally     <= tally_next;
      ticks     <= ticks_next;
      last_freq <= freq_next;
    end
  end

endmodule

// ===== rtl/core/debounced_quadrature_counter.sv =====
// debounced quadrature counter; each accepted word passes the input register and
// the result register, throughput one word per cycle unless out_ready stalls;
// they flank one pass of debounce, position clamp and window logic
// rst is synchronous: clears both pipeline valid flags and all counter state and
// loads the configuration registers with their defaults
// depends on dqc_pkg, dqc_debounce, dqc_position, dqc_freq and assert_macros.svh
`include "assert_macros.svh"

module debounced_quadrature_counter #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [dqc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dqc_pkg::DATA_W-1:0]          cfg_data,
  // input word
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                channel_a,
  input  logic                                channel_b,
  input  logic                                overwrite_valid,
  input  logic [dqc_pkg::DATA_W-1:0]          overwrite_value,
  // result word
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dqc_pkg::DATA_W-1:0]          position,
  output logic [dqc_pkg::DATA_W-1:0]          frequency,
  output logic                                level
);

  logic [dqc_pkg::DATA_W-1:0] debounce_samples;
  dqc_pkg::edge_mode_t        edge_mode;
  logic [dqc_pkg::DATA_W-1:0] step_size;
  logic [dqc_pkg::DATA_W-1:0] min_limit;
  logic [dqc_pkg::DATA_W-1:0] max_limit;
  logic [dqc_pkg::DATA_W-1:0] freq_window;
  logic                       window_clear;

  logic                       s1_valid;
  logic                       s1_a;
  logic                       s1_b;
  logic                       s1_ow_valid;
  logic [dqc_pkg::DATA_W-1:0] s1_ow_value;
  logic                       s1_adv;
  logic                       in_accept;

  dqc_pkg::a_edge_t           edges;
  logic                       level_q;
  logic                       level_next;
  logic [dqc_pkg::DATA_W-1:0] pos_q;
  logic [dqc_pkg::DATA_W-1:0] pos_next;
  logic [dqc_pkg::DATA_W-1:0] freq_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_samples <= '0;
      edge_mode        <= dqc_pkg::EDGE_FALLING;
      step_size        <= dqc_pkg::STEP_DEFAULT;
      min_limit        <= dqc_pkg::LIMIT_OFF_LOW;
      max_limit        <= dqc_pkg::LIMIT_OFF_HIGH;
      freq_window      <= dqc_pkg::WINDOW_DEFAULT;
    end else if (cfg_write) begin
      unique case (dqc_pkg::cfg_reg_t'(cfg_index))
        dqc_pkg::CFG_DEBOUNCE_SAMPLES: debounce_samples <= cfg_data;
        dqc_pkg::CFG_EDGE_MODE:        edge_mode <= dqc_pkg::edge_mode_t'(cfg_data[1:0]);
        dqc_pkg::CFG_STEP_SIZE:        step_size <= cfg_data;
        dqc_pkg::CFG_MIN_LIMIT:        min_limit <= cfg_data;
        dqc_pkg::CFG_MAX_LIMIT:        max_limit <= cfg_data;
        dqc_pkg::CFG_FREQ_WINDOW:      freq_window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign window_clear = cfg_write && (cfg_index == dqc_pkg::CFG_FREQ_WINDOW);

  // handshake: the input register moves on whenever the result register frees up
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_a        <= channel_a;
      s1_b        <= channel_b;
      s1_ow_valid <= overwrite_valid;
      s1_ow_value <= overwrite_value;
    end
  end

  // debounce of channel a
  dqc_debounce #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_debounce (
    .clk              (clk),
    .rst              (rst),
    .adv              (s1_adv),
    .a                (s1_a),
    .debounce_samples (debounce_samples),
    .edges            (edges),
    .level_q          (level_q),
    .level_next       (level_next)
  );

  // position update
  dqc_position u_position (
    .clk              (clk),
    .rst              (rst),
    .adv              (s1_adv),
    .edges            (edges),
    .b                (s1_b),
    .overwrite_valid  (s1_ow_valid),
    .overwrite_value  (s1_ow_value),
    .edge_mode        (edge_mode),
    .step_size        (step_size),
    .min_limit        (min_limit),
    .max_limit        (max_limit),
    .pos_q            (pos_q),
    .pos_next         (pos_next)
  );

  // frequency window
  dqc_freq #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_freq (
    .clk          (clk),
    .rst          (rst),
    .adv          (s1_adv),
    .clear        (window_clear),
    .rise         (edges.rise),
    .freq_window  (freq_window),
    .freq_next    (freq_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      position  <= pos_next;
      frequency <= freq_next;
      level     <= level_next;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_edge_excl, clk, rst, !(edges.rise && edges.fall))
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASSERT_IMPLY(a_level_needs_edge, clk, rst, level_next != level_q, edges.rise || edges.fall)
  `ASSERT_IMPLY(a_pos_hold, clk, rst, !edges.rise && !edges.fall && !s1_ow_valid, pos_next == pos_q)
  `ASSERT_IMPLY(a_result_matches_state, clk, rst, out_valid && !s1_valid, level == level_q && position == pos_q)

endmodule

// ===== tb/debounced_quadrature_counter_tb.sv =====
// self-checking testbench of debounced_quadrature_counter: directed table, then random phases
// accepted words are scored against typed rows or a model of debounce, position and frequency
// depends on dqc_pkg and the debounced_quadrature_counter rtl
`timescale 1ns / 100ps

module debounced_quadrature_counter_tb;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 4;
  localparam int PIPE_LATENCY = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int WORDS_PER_PHASE = 125;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_REPORTS = 40;
  localparam int DIRECTED_ROWS = 25;
  // register indexes that decode to nothing
  localparam logic [dqc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [dqc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic                       a;
    logic                       b;
    logic                       ow_valid;
    logic [dqc_pkg::DATA_W-1:0] ow_value;
  } tick_word_t;

  typedef struct packed {
    logic [dqc_pkg::DATA_W-1:0] position;
    logic [dqc_pkg::DATA_W-1:0] frequency;
    logic                       level;
  } reading_t;

  typedef struct packed {
    logic                          do_cfg;
    logic [dqc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [dqc_pkg::DATA_W-1:0]    cfg_val;
    tick_word_t                    word;
    logic                          typed;
    reading_t                      want;
  } row_t;

  // dut connections
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [dqc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dqc_pkg::DATA_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          channel_a = 1'b0;
  logic                          channel_b = 1'b0;
  logic                          overwrite_valid = 1'b0;
  logic [dqc_pkg::DATA_W-1:0]    overwrite_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [dqc_pkg::DATA_W-1:0]    position;
  logic [dqc_pkg::DATA_W-1:0]    frequency;
  logic                          level;

  debounced_quadrature_counter dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .channel_a(channel_a), .channel_b(channel_b),
    .overwrite_valid(overwrite_valid), .overwrite_value(overwrite_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .frequency(frequency), .level(level)
  );

  always #HALF_PERIOD clk = ~clk;

  // model copy of the configuration registers
  logic [dqc_pkg::DATA_W-1:0] thr_samples = '0;
  dqc_pkg::edge_mode_t        mode = dqc_pkg::EDGE_FALLING;
  logic [dqc_pkg::DATA_W-1:0] step_amt = dqc_pkg::STEP_DEFAULT;
  logic [dqc_pkg::DATA_W-1:0] floor_lim = dqc_pkg::LIMIT_OFF_LOW;
  logic [dqc_pkg::DATA_W-1:0] ceil_lim = dqc_pkg::LIMIT_OFF_HIGH;
  logic [dqc_pkg::DATA_W-1:0] window_len = dqc_pkg::WINDOW_DEFAULT;

  // model copy of the counter state
  logic                       lvl_model = 1'b0;
  logic [15:0]                run_count = '0;
  logic [dqc_pkg::DATA_W-1:0] pos_model = '0;
  logic [15:0]                rise_tally = '0;
  logic [15:0]                tick_count = '0;
  logic [dqc_pkg::DATA_W-1:0] freq_hold = '0;

  reading_t readings_due[$];
  int err_count = 0;
  int words_sent = 0;
  int readings_seen = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_done = 0;
  int hold_left = 0;
  row_t rows[DIRECTED_ROWS];

  // position after one counted edge, clamped to the enabled limits
  function automatic logic [dqc_pkg::DATA_W-1:0] stepped_position(input logic up);
    int sum;
    int lo;
    int hi;
    sum = int'(pos_model);
    lo = int'(floor_lim);
    hi = int'(ceil_lim);
    if (up) sum = sum + int'(step_amt);
    else sum = sum - int'(step_amt);
    if (ceil_lim != dqc_pkg::LIMIT_OFF_HIGH && sum > hi) sum = hi;
    if (floor_lim != dqc_pkg::LIMIT_OFF_LOW && sum < lo) sum = lo;
    return sum[dqc_pkg::DATA_W-1:0];
  endfunction

  // one sample tick: overwrite, debounce of channel a, then the frequency window
  function automatic reading_t sample_tick(input tick_word_t w);
    reading_t r;
    if (w.ow_valid) pos_model = w.ow_value;
    if (w.a) begin
      if (!lvl_model) begin
        run_count = run_count + 16'd1;
        if (run_count >= thr_samples) begin
          rise_tally = rise_tally + 16'd1;
          lvl_model = 1'b1;
          if (mode == dqc_pkg::EDGE_RISING || mode == dqc_pkg::EDGE_BOTH)
            pos_model = stepped_position(w.b);
          run_count = '0;
        end
      end else begin
        run_count = '0;
      end
    end else begin
      if (lvl_model) begin
        run_count = run_count + 16'd1;
        if (run_count > thr_samples) begin
          lvl_model = 1'b0;
          if (mode == dqc_pkg::EDGE_FALLING || mode == dqc_pkg::EDGE_BOTH)
            pos_model = stepped_position(!w.b);
          run_count = '0;
        end
      end else begin
        run_count = '0;
      end
    end
    if (window_len != '0) begin
      tick_count = tick_count + 16'd1;
      if (tick_count >= window_len) begin
        freq_hold = rise_tally;
        rise_tally = '0;
        tick_count = '0;
      end
    end
    r.position = pos_model;
    r.frequency = freq_hold;
    r.level = lvl_model;
    return r;
  endfunction

  // offer one word, hold it until accepted, then queue its reading
  task automatic send_word(input tick_word_t w, input logic typed, input reading_t want);
    reading_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel_a <= w.a;
    channel_b <= w.b;
    overwrite_valid <= w.ow_valid;
    overwrite_value <= w.ow_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = sample_tick(w);
    readings_due.push_back(typed ? want : r);
    words_sent++;
  endtask

  // all readings in, then let the pipeline settle
  task automatic wait_idle();
    while (readings_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // register write, mirrored into the model at the same edge
  task automatic write_reg(input logic [dqc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dqc_pkg::DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      dqc_pkg::CFG_DEBOUNCE_SAMPLES: thr_samples = data;
      dqc_pkg::CFG_EDGE_MODE:        mode = dqc_pkg::edge_mode_t'(data[1:0]);
      dqc_pkg::CFG_STEP_SIZE:        step_amt = data;
      dqc_pkg::CFG_MIN_LIMIT:        floor_lim = data;
      dqc_pkg::CFG_MAX_LIMIT:        ceil_lim = data;
      dqc_pkg::CFG_FREQ_WINDOW: begin
        window_len = data;
        rise_tally = '0;
        tick_count = '0;
        freq_hold = '0;
      end
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t mk(input logic do_cfg, input logic [dqc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [dqc_pkg::DATA_W-1:0] val, input logic a,
                              input logic b, input logic ow,
                              input logic [dqc_pkg::DATA_W-1:0] owv, input logic typed,
                              input logic [dqc_pkg::DATA_W-1:0] pos,
                              input logic [dqc_pkg::DATA_W-1:0] freq, input logic lvl);
    row_t r;
    r.do_cfg = do_cfg;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.word = '{a: a, b: b, ow_valid: ow, ow_value: owv};
    r.typed = typed;
    r.want = '{position: pos, frequency: freq, level: lvl};
    return r;
  endfunction

  // settings of one random phase; the first keeps defaults, the second and last take extremes
  task automatic set_phase_config(input int p);
    logic [dqc_pkg::DATA_W-1:0] dbs;
    logic [dqc_pkg::DATA_W-1:0] stp;
    logic [dqc_pkg::DATA_W-1:0] lo;
    logic [dqc_pkg::DATA_W-1:0] hi;
    logic [dqc_pkg::DATA_W-1:0] win;
    logic [dqc_pkg::DATA_W-1:0] mode_word;
    dbs = 16'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: stp = '0;
      1: stp = 16'd1;
      2: stp = 16'hFFFF;
      3: stp = 16'($urandom_range(2, 300));
      default: stp = 16'($urandom);
    endcase
    lo = ($urandom_range(0, 1) == 0) ? dqc_pkg::LIMIT_OFF_LOW : 16'($urandom);
    hi = ($urandom_range(0, 1) == 0) ? dqc_pkg::LIMIT_OFF_HIGH : 16'($urandom);
    case ($urandom_range(0, 3))
      0: win = '0;
      1: win = 16'd1;
      2: win = 16'($urandom_range(2, 40));
      default: win = 16'hFFFF;
    endcase
    mode_word = {14'($urandom), 2'(p % 4)};
    if (p == 0) begin
      dbs = '0;
      stp = 16'd1;
      lo = dqc_pkg::LIMIT_OFF_LOW;
      hi = dqc_pkg::LIMIT_OFF_HIGH;
      win = dqc_pkg::WINDOW_DEFAULT;
    end else if (p == 1) begin
      dbs = 16'd1;
      stp = 16'hFFFF;
      lo = '0;
      hi = 16'hFFFF;
      win = 16'd1;
    end else if (p == RAND_PHASES - 1) begin
      dbs = 16'hFFFF;
      stp = 16'hFFFF;
      lo = '0;
      hi = 16'hFFFF;
      win = 16'hFFFF;
    end
    write_reg(dqc_pkg::CFG_DEBOUNCE_SAMPLES, dbs);
    write_reg(dqc_pkg::CFG_EDGE_MODE, mode_word);
    write_reg(dqc_pkg::CFG_STEP_SIZE, stp);
    write_reg(dqc_pkg::CFG_MIN_LIMIT, lo);
    write_reg(dqc_pkg::CFG_MAX_LIMIT, hi);
    write_reg(dqc_pkg::CFG_FREQ_WINDOW, win);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_ask != hold_done) begin
      hold_done = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [dqc_pkg::DATA_W-1:0] want,
                             input logic [dqc_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // score each result word against the oldest pending reading
  always @(posedge clk) begin
    reading_t w;
    if (!rst && out_valid && out_ready) begin
      readings_seen++;
      if (readings_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got %0h %0h %0b",
                   $time, position, frequency, level);
      end else begin
        w = readings_due.pop_front();
        check_field("position", w.position, position);
        check_field("frequency", w.frequency, frequency);
        check_field("level", {15'd0, w.level}, {15'd0, level});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d readings pending", $time, readings_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    tick_word_t w;
    logic a_lvl;
    int run_left;
    int run_max;

    // directed table: reset values, wrap, limits, min over max, debounce counts, window
    rows[0]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b1, 16'h0000, 16'd0, 1'b0);
    rows[1]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF,
                  1'b1, 16'hFFFF, 16'd0, 1'b0);
    rows[2]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b1, 16'hFFFF, 16'd0, 1'b1);
    rows[3]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[4]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[5]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[6]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[7]  = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[8]  = mk(1'b1, dqc_pkg::CFG_STEP_SIZE, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'h0000,
                  1'b1, 16'h0000, 16'd0, 1'b0);
    rows[9]  = mk(1'b1, dqc_pkg::CFG_EDGE_MODE, 16'(dqc_pkg::EDGE_BOTH), 1'b1, 1'b1, 1'b0,
                  16'h0000, 1'b0, 16'd0, 16'd0, 1'b0);
    rows[10] = mk(1'b1, dqc_pkg::CFG_MAX_LIMIT, 16'd100, 1'b0, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[11] = mk(1'b1, dqc_pkg::CFG_MIN_LIMIT, 16'd10, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[12] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    // a limit write leaves the position where it was
    rows[13] = mk(1'b1, dqc_pkg::CFG_MIN_LIMIT, 16'd50, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b1, 16'd10, 16'd0, 1'b0);
    rows[14] = mk(1'b1, dqc_pkg::CFG_MAX_LIMIT, 16'd20, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[15] = mk(1'b1, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd2, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[16] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[17] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[18] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[19] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[20] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[21] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[22] = mk(1'b0, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[23] = mk(1'b1, dqc_pkg::CFG_DEBOUNCE_SAMPLES, 16'd0, 1'b0, 1'b0, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);
    rows[24] = mk(1'b1, dqc_pkg::CFG_FREQ_WINDOW, 16'd1, 1'b1, 1'b1, 1'b0, 16'h0000,
                  1'b0, 16'd0, 16'd0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (rows[i].do_cfg) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      end
      send_word(rows[i].word, rows[i].typed, rows[i].want);
    end
    in_valid <= 1'b0;
    wait_idle();

    // writes to unused indexes must change nothing
    write_reg(CFG_SPARE_A, 16'($urandom));
    write_reg(CFG_SPARE_B, 16'hFFFF);

    // random phases; channel a moves in runs sized to the debounce setting, with glitches
    a_lvl = 1'b0;
    run_left = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_phase_config(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      run_max = (thr_samples < 16'd8) ? int'(thr_samples) + 3 : 8;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // long receiver hold-off while words keep coming, so the input backs up
        if (p == 4 && k == 20) hold_ask++;
        if (run_left == 0) begin
          a_lvl = ~a_lvl;
          run_left = int'($urandom_range(1, run_max));
        end
        run_left--;
        w.a = ($urandom_range(0, 7) == 0) ? ~a_lvl : a_lvl;
        w.b = 1'($urandom_range(0, 1));
        w.ow_valid = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 7))
          0: w.ow_value = '0;
          1: w.ow_value = 16'hFFFF;
          default: w.ow_value = 16'($urandom);
        endcase
        send_word(w, 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    // drain and look for stray words
    while (readings_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("run covered %0d words over %0d random phases plus the directed table",
             words_sent, RAND_PHASES);
    $display("%0d result words scored, %0d mismatches", readings_seen, err_count);
    if (err_count == 0 && readings_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
